FILE: design/crs_pkg.sv
// Shared types, action codes and helpers for the clip rectangle stack.
// Used by every module of the block but the RAM, and by its port checkers and testbench.
package crs_pkg;

  localparam int STACK_DEPTH_DFLT = 8;
  localparam int COORD_W          = 16;
  localparam int ACT_W            = 3;
  localparam int LEVEL_W          = 4;

  localparam logic [ACT_W-1:0] ACT_PUSH  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_POP   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_CLIP  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_LINE  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd4;

  typedef struct packed {
    logic [ACT_W-1:0]          action;
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
  } crs_req_t;

  typedef struct packed {
    logic                      ok;
    logic signed [COORD_W-1:0] res_x1;
    logic signed [COORD_W-1:0] res_y1;
    logic signed [COORD_W-1:0] res_x2;
    logic signed [COORD_W-1:0] res_y2;
    logic [LEVEL_W-1:0]        level;
  } crs_rsp_t;

  // x1/y1 is the min corner, x2/y2 the max corner.
  typedef struct packed {
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
    logic signed [COORD_W-1:0] x2;
    logic signed [COORD_W-1:0] y2;
  } rect_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } crs_upd_t;

  function automatic logic signed [COORD_W-1:0] smax(input logic signed [COORD_W-1:0] a,
                                                      input logic signed [COORD_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic signed [COORD_W-1:0] smin(input logic signed [COORD_W-1:0] a,
                                                      input logic signed [COORD_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

FILE: design/clip_rect_stack.sv
// Clip rectangle stack: an accepted request is registered, evaluated, and its result
// registered; one request per cycle sustained when the result side does not stall.
// The top entry lives in a register; the entry below it is always read ahead
// from the stack RAM, so a pop makes it the new top without a wait.
// Reset (rst, synchronous) empties the stack and drops any held request or result;
// stack RAM contents are left as they are.
module clip_rect_stack #(
  parameter int STACK_DEPTH = crs_pkg::STACK_DEPTH_DFLT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  crs_pkg::crs_req_t req_data,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output crs_pkg::crs_rsp_t rsp_data
);
  import crs_pkg::*;

  localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int RECT_W = $bits(rect_t);

  logic             in_vld;
  crs_req_t         in_req;
  logic [LVL_W-1:0] level;
  logic [LVL_W-1:0] level_next;
  logic [LVL_W-1:0] below_lvl;
  rect_t            top;
  rect_t            alu_rect;
  logic             alu_ok;
  crs_upd_t         upd;
  logic             fire;
  logic [RECT_W-1:0] below_raw;

  assign fire      = in_vld && (!rsp_valid || !rsp_stall);
  assign req_stall = in_vld && !fire;

  crs_alu #(
    .STACK_DEPTH(STACK_DEPTH),
    .LVL_W      (LVL_W)
  ) u_alu (
    .req  (in_req),
    .level(level),
    .top  (top),
    .rect (alu_rect),
    .ok   (alu_ok),
    .upd  (upd)
  );

  always_comb begin
    level_next = level;
    if (fire) begin
      priority if (upd.clear) begin
        level_next = '0;
      end else if (upd.push) begin
        level_next = level + LVL_W'(1);
      end else if (upd.pop) begin
        level_next = level - LVL_W'(1);
      end
    end
  end

  // Read ahead the entry that will sit just below the top once this request is done.
  assign below_lvl = level_next - LVL_W'(2);

  crs_ram #(
    .WIDTH(RECT_W),
    .DEPTH(STACK_DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (fire && upd.push),
    .wr_addr(level[ADDR_W-1:0]),
    .wr_data(alu_rect),
    .rd_addr(below_lvl[ADDR_W-1:0]),
    .rd_data(below_raw)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld    <= 1'b0;
      rsp_valid <= 1'b0;
      level     <= '0;
    end else begin
      if (!req_stall) begin
        in_vld <= req_valid;
      end
      if (fire) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      level <= level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall) begin
      in_req <= req_data;
    end
    if (fire) begin
      rsp_data <= '{ok: alu_ok, res_x1: alu_rect.x1, res_y1: alu_rect.y1,
                    res_x2: alu_rect.x2, res_y2: alu_rect.y2,
                    level: LEVEL_W'(level_next)};
      if (upd.push) begin
        top <= alu_rect;
      end else if (upd.pop) begin
        top <= rect_t'(below_raw);
      end
    end
  end

endmodule

FILE: design/crs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module crs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: design/crs_alu.sv
// Combinational evaluation of one request against the current top rectangle.
// Depends on crs_pkg for the request, rectangle and update types.
module crs_alu #(
  parameter int STACK_DEPTH = crs_pkg::STACK_DEPTH_DFLT,
  parameter int LVL_W       = $clog2(STACK_DEPTH + 1)
) (
  input  crs_pkg::crs_req_t req,
  input  logic [LVL_W-1:0]  level,
  input  crs_pkg::rect_t    top,
  output crs_pkg::rect_t    rect,
  output logic              ok,
  output crs_pkg::crs_upd_t upd
);
  import crs_pkg::*;

  logic  have_top;
  logic  full;
  rect_t isect;
  rect_t echo;
  logic signed [COORD_W-1:0] lx, hx, ly, hy;

  assign have_top = (level != '0);
  assign full     = (level == LVL_W'(STACK_DEPTH));

  assign echo  = '{x1: req.ax, y1: req.ay, x2: req.bx, y2: req.by};
  assign isect = '{x1: smax(req.ax, top.x1), y1: smax(req.ay, top.y1),
                   x2: smin(req.bx, top.x2), y2: smin(req.by, top.y2)};

  assign lx = smin(req.ax, req.bx);
  assign hx = smax(req.ax, req.bx);
  assign ly = smin(req.ay, req.by);
  assign hy = smax(req.ay, req.by);

  always_comb begin
    rect = echo;
    ok   = 1'b0;
    upd  = '0;
    unique case (req.action)
      ACT_PUSH: begin
        if (!full) begin
          rect     = have_top ? isect : echo;
          ok       = 1'b1;
          upd.push = 1'b1;
        end
      end
      ACT_POP: begin
        if (have_top) begin
          ok      = 1'b1;
          upd.pop = 1'b1;
        end
      end
      ACT_CLIP: begin
        if (have_top) begin
          rect = isect;
          ok   = (isect.x1 <= isect.x2) && (isect.y1 <= isect.y2);
        end else begin
          ok = 1'b1;
        end
      end
      ACT_LINE: begin
        if (have_top) begin
          ok = !((hx < top.x1) || (hy < top.y1) || (lx > top.x2) || (ly > top.y2));
        end else begin
          ok = 1'b1;
        end
      end
      ACT_CLEAR: begin
        ok        = 1'b1;
        upd.clear = 1'b1;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

endmodule

FILE: design/crs_checker.sv
// Port-level checks for clip_rect_stack, attached by the bind at the end.
// Depends on crs_pkg for the request and result types.
module crs_port_props #(
  parameter int STACK_DEPTH = crs_pkg::STACK_DEPTH_DFLT
) (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_stall,
  input crs_pkg::crs_req_t req_data,
  input logic              rsp_valid,
  input logic              rsp_stall,
  input crs_pkg::crs_rsp_t rsp_data
);
  import crs_pkg::*;

  logic [LEVEL_W-1:0] last_level;
  logic               rsp_acc;

  assign rsp_acc = rsp_valid && !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level <= '0;
    end else if (rsp_acc) begin
      last_level <= rsp_data.level;
    end
  end

  // After reset nothing is offered and new requests are taken.
  a_reset_idle: assert property (@(posedge clk) rst |=> !rsp_valid && !req_stall)
    else $error("result valid or request stalled right after reset");

  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_stall |=> req_valid && $stable(req_data))
    else $error("stalled request changed or was withdrawn");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
    else $error("stalled result changed or was dropped");

  // The level field only holds the low bits of the depth, so the bound is
  // meaningful only while the depth fits in it.
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (STACK_DEPTH > 15) || (rsp_data.level <= LEVEL_W'(STACK_DEPTH)))
    else $error("stack level beyond the depth");

  // One request moves the depth by at most one, or clears it.
  a_level_step: assert property (@(posedge clk) disable iff (rst)
    rsp_acc |-> (rsp_data.level == last_level) ||
                (rsp_data.level == last_level + LEVEL_W'(1)) ||
                (rsp_data.level == last_level - LEVEL_W'(1)) ||
                (rsp_data.level == '0))
    else $error("stack level jumped between results");

endmodule

bind clip_rect_stack crs_port_props #(.STACK_DEPTH(STACK_DEPTH)) u_crs_checker (.*);

FILE: test/crs_checker.sv
`timescale 1ns / 1ps
// Port checker for the clip rectangle stack: watches both handshake channels,
// predicts each result from its own copy of the stack and compares field by field.
// Depends on crs_pkg for the request, result and rectangle types.
module crs_checker import crs_pkg::*; #(
  parameter int DEPTH = STACK_DEPTH_DFLT
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  input  logic     req_stall,
  input  crs_req_t req_data,
  input  logic     rsp_valid,
  input  logic     rsp_stall,
  input  crs_rsp_t rsp_data,
  output int       errors,
  output int       pending,
  output int       checked
);

  rect_t    stack_rects [DEPTH];
  int       stack_depth;
  crs_rsp_t expected_q [$];

  initial begin
    errors      = 0;
    pending     = 0;
    checked     = 0;
    stack_depth = 0;
  end

  function automatic logic signed [COORD_W-1:0] lower_edge(input logic signed [COORD_W-1:0] a,
                                                           input logic signed [COORD_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [COORD_W-1:0] upper_edge(input logic signed [COORD_W-1:0] a,
                                                           input logic signed [COORD_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  // Works out the result of one request and moves the stack on by it.
  function automatic crs_rsp_t predict_result(input crs_req_t r);
    crs_rsp_t e;
    rect_t    top;
    rect_t    n;
    logic     has_top;
    logic signed [COORD_W-1:0] lo_x, hi_x, lo_y, hi_y;
    e.ok     = 1'b0;
    e.res_x1 = r.ax;
    e.res_y1 = r.ay;
    e.res_x2 = r.bx;
    e.res_y2 = r.by;
    has_top  = (stack_depth > 0);
    top      = '0;
    if (has_top) begin
      top = stack_rects[stack_depth - 1];
    end
    case (r.action)
      ACT_PUSH: begin
        if (stack_depth < DEPTH) begin
          n.x1 = r.ax;
          n.y1 = r.ay;
          n.x2 = r.bx;
          n.y2 = r.by;
          if (has_top) begin
            n.x1 = upper_edge(n.x1, top.x1);
            n.y1 = upper_edge(n.y1, top.y1);
            n.x2 = lower_edge(n.x2, top.x2);
            n.y2 = lower_edge(n.y2, top.y2);
          end
          // An empty intersection is stored all the same.
          stack_rects[stack_depth] = n;
          stack_depth++;
          e.res_x1 = n.x1;
          e.res_y1 = n.y1;
          e.res_x2 = n.x2;
          e.res_y2 = n.y2;
          e.ok     = 1'b1;
        end
      end
      ACT_POP: begin
        if (stack_depth > 0) begin
          stack_depth--;
          e.ok = 1'b1;
        end
      end
      ACT_CLIP: begin
        if (has_top) begin
          e.res_x1 = upper_edge(r.ax, top.x1);
          e.res_y1 = upper_edge(r.ay, top.y1);
          e.res_x2 = lower_edge(r.bx, top.x2);
          e.res_y2 = lower_edge(r.by, top.y2);
          e.ok     = (e.res_x1 <= e.res_x2) && (e.res_y1 <= e.res_y2);
        end else begin
          e.ok = 1'b1;
        end
      end
      ACT_LINE: begin
        if (has_top) begin
          lo_x = lower_edge(r.ax, r.bx);
          hi_x = upper_edge(r.ax, r.bx);
          lo_y = lower_edge(r.ay, r.by);
          hi_y = upper_edge(r.ay, r.by);
          e.ok = !(hi_x < top.x1 || hi_y < top.y1 || lo_x > top.x2 || lo_y > top.y2);
        end else begin
          e.ok = 1'b1;
        end
      end
      ACT_CLEAR: begin
        stack_depth = 0;
        e.ok        = 1'b1;
      end
      default: begin
      end
    endcase
    e.level = LEVEL_W'(stack_depth);
    return e;
  endfunction

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      errors++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  task automatic compare_result(input crs_rsp_t want, input crs_rsp_t got);
    checked++;
    check_field("ok", want.ok, got.ok);
    check_field("res_x1", $signed(want.res_x1), $signed(got.res_x1));
    check_field("res_y1", $signed(want.res_y1), $signed(got.res_y1));
    check_field("res_x2", $signed(want.res_x2), $signed(got.res_x2));
    check_field("res_y2", $signed(want.res_y2), $signed(got.res_y2));
    check_field("level", want.level, got.level);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      stack_depth = 0;
      expected_q.delete();
    end else begin
      if (req_valid && !req_stall) begin
        expected_q.push_back(predict_result(req_data));
      end
      if (rsp_valid && !rsp_stall) begin
        if (expected_q.size() == 0) begin
          errors++;
          $error("result accepted with no request outstanding");
        end else begin
          compare_result(expected_q.pop_front(), rsp_data);
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// Testbench top for the clip rectangle stack: drives directed and random requests
// under several idling patterns and gives the verdict. Depends on crs_pkg,
// clip_rect_stack and crs_checker.
module tb;
  import crs_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_BLOCKS = 8;
  localparam int BLOCK_LEN   = 195;
  localparam int DRAIN_WAIT  = 8;

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_stall;
  crs_req_t req_data  = '0;
  logic     rsp_valid;
  logic     rsp_stall = 1'b0;
  crs_rsp_t rsp_data;

  int gap_pct     = 0;
  int stall_pct   = 0;
  int sent        = 0;
  int cycle_count = 0;
  int errors;
  int pending;
  int checked;

  always #2 clk = ~clk;

  clip_rect_stack dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

  crs_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data),
    .errors    (errors),
    .pending   (pending),
    .checked   (checked)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  function automatic crs_req_t make_req(input logic [ACT_W-1:0] act, input int x1, input int y1,
                                        input int x2, input int y2);
    crs_req_t r;
    r.action = act;
    r.ax     = COORD_W'(x1);
    r.ay     = COORD_W'(y1);
    r.bx     = COORD_W'(x2);
    r.by     = COORD_W'(y2);
    return r;
  endfunction

  function automatic logic signed [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      1, 2:    return COORD_W'($urandom);
      default: return COORD_W'(int'($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  // Mostly well-formed rectangles so that pushes nest and clips keep something.
  function automatic crs_req_t random_req();
    crs_req_t r;
    int       pick;
    logic signed [COORD_W-1:0] t;
    pick = $urandom_range(0, 99);
    if (pick < 26) begin
      r.action = ACT_PUSH;
    end else if (pick < 46) begin
      r.action = ACT_POP;
    end else if (pick < 70) begin
      r.action = ACT_CLIP;
    end else if (pick < 92) begin
      r.action = ACT_LINE;
    end else if (pick < 95) begin
      r.action = ACT_CLEAR;
    end else begin
      r.action = ACT_W'($urandom_range(int'(ACT_CLEAR) + 1, (1 << ACT_W) - 1));
    end
    r.ax = pick_coord();
    r.ay = pick_coord();
    r.bx = pick_coord();
    r.by = pick_coord();
    if (r.action != ACT_LINE && $urandom_range(0, 9) < 8) begin
      if (r.ax > r.bx) begin
        t    = r.ax;
        r.ax = r.bx;
        r.bx = t;
      end
      if (r.ay > r.by) begin
        t    = r.ay;
        r.ay = r.by;
        r.by = t;
      end
    end
    return r;
  endfunction

  // Holds the request steady until the block takes it.
  task automatic send_req(input crs_req_t r);
    while ($urandom_range(0, 99) < gap_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    @(posedge clk);
    while (req_stall) begin
      @(posedge clk);
    end
    sent++;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Empty stack: pop fails, clip and line pass untouched, unknown action ignored.
    send_req(make_req(ACT_POP, 1, 2, 3, 4));
    send_req(make_req(ACT_CLIP, -32768, 32767, 32767, -32768));
    send_req(make_req(ACT_LINE, 32767, -32768, -32768, 32767));
    send_req(make_req(ACT_W'(int'(ACT_CLEAR) + 1), -1, 0, 1, -32768));
    // Nesting, clamping, empty clips, lines off two sides of the top entry and one across it.
    send_req(make_req(ACT_PUSH, -32768, -32768, 32767, 32767));
    send_req(make_req(ACT_PUSH, -100, -50, 200, 150));
    send_req(make_req(ACT_CLIP, -1000, 0, 50, 1000));
    send_req(make_req(ACT_CLIP, 300, 0, 400, 10));
    send_req(make_req(ACT_LINE, -500, 0, -200, 10));
    send_req(make_req(ACT_LINE, 0, 151, 10, 900));
    send_req(make_req(ACT_LINE, 300, -300, -300, 300));
    send_req(make_req(ACT_CLIP, -32768, -32768, 32767, 32767));
    // An empty intersection is still stored; then fill the stack and push once more.
    send_req(make_req(ACT_PUSH, 500, 500, 600, 600));
    send_req(make_req(ACT_CLIP, 0, 0, 10, 10));
    send_req(make_req(ACT_PUSH, -32768, -32768, 32767, 32767));
    send_req(make_req(ACT_PUSH, 0, 0, 0, 0));
    send_req(make_req(ACT_PUSH, 32767, 32767, -32768, -32768));
    send_req(make_req(ACT_PUSH, -7, 3, 9, 12));
    send_req(make_req(ACT_PUSH, 1, 1, 2, 2));
    send_req(make_req(ACT_PUSH, 5, 6, 7, 8));
    send_req(make_req(ACT_POP, 0, 0, 0, 0));
    send_req(make_req(ACT_W'(int'(ACT_CLEAR) + 2), 32767, 32767, 32767, 32767));
    send_req(make_req(ACT_W'(int'(ACT_CLEAR) + 3), -32768, -32768, -32768, -32768));
    send_req(make_req(ACT_CLEAR, 11, 22, 33, 44));
    send_req(make_req(ACT_POP, -1, -1, -1, -1));

    for (int blk = 0; blk < RAND_BLOCKS; blk++) begin
      case (blk % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 55; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 55; end
        default: begin gap_pct = 10; stall_pct = 10; end
      endcase
      repeat (BLOCK_LEN) send_req(random_req());
    end
    req_valid <= 1'b0;

    while (pending != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Summary: %0d requests sent under four idling patterns, %0d results compared.",
             sent, checked);
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
